// File: src/assert_macros.svh
// Assertion macros used by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication or plain expression checked on every clock outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// File: src/b64enc_pkg.sv
// Types, constants and the symbol table of the Base64 stream encoder.
`default_nettype none
package b64enc_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    localparam logic [1:0] CHAR_IDX_FIRST  = 2'd0;
    localparam logic [1:0] CHAR_IDX_SECOND = 2'd1;
    localparam logic [1:0] CHAR_IDX_THIRD  = 2'd2;
    localparam logic [1:0] CHAR_IDX_FOURTH = 2'd3;

    localparam logic [1:0] NBYTES_ONE   = 2'd1;
    localparam logic [1:0] NBYTES_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] code_char;
        logic       last_char;
    } out_item_t;

    // One group of up to three bytes, ready for conversion.
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  nbytes;
        logic        eom;
    } group_t;

    function automatic logic [7:0] symbol_of(input logic [5:0] v);
        logic [7:0] r;
        logic [5:0] m;
        begin
            m = v & SEXTET_MASK;
            if (m < 6'd26)
                r = 8'd65 + {2'b00, m};
            else if (m < 6'd52)
                r = 8'd97 + {2'b00, m - 6'd26};
            else if (m < 6'd62)
                r = 8'd48 + {2'b00, m - 6'd52};
            else if (m == 6'd62)
                r = PLUS_CHAR;
            else
                r = SLASH_CHAR;
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// File: src/b64enc_front.sv
// Front end: accepts bytes, gathers them into groups, pushes each group on its third byte or end of message.
`default_nettype none
module b64enc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire b64enc_pkg::in_item_t  in_item,
    output logic                       push,
    output b64enc_pkg::group_t         push_group,
    input  wire logic                  queue_full
);
    import b64enc_pkg::*;

    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic [1:0]  cnt_eff;
    logic        accept;
    logic        hold;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign cnt_eff  = (held_count_reg == 2'd3) ? 2'd2 : held_count_reg;
    assign hold     = (cnt_eff != 2'd2) && !in_item.end_of_message;
    assign push     = accept && !hold;

    always_comb
    begin
        push_group.eom    = in_item.end_of_message;
        push_group.nbytes = cnt_eff + 2'd1;
        case (cnt_eff)
            2'd0:    push_group.triple = {in_item.data_byte, 16'h0000};
            2'd1:    push_group.triple = {held_bytes_reg[15:8], in_item.data_byte, 8'h00};
            default: push_group.triple = {held_bytes_reg, in_item.data_byte};
        endcase
    end

    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        if (accept)
        begin
            if (hold)
            begin
                if (cnt_eff == 2'd0)
                    held_bytes_next = {in_item.data_byte, 8'h00};
                else
                    held_bytes_next = {held_bytes_reg[15:8], in_item.data_byte};
                held_count_next = cnt_eff + 2'd1;
            end
            else
            begin
                held_bytes_next = 16'h0000;
                held_count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= 16'h0000;
            held_count_reg <= 2'd0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule
`default_nettype wire

// File: src/b64enc_queue.sv
// Small register FIFO of byte groups between front and back end.
`default_nettype none
module b64enc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire b64enc_pkg::group_t push_group,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output b64enc_pkg::group_t      head
);
    import b64enc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    group_t          slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: src/b64enc_back.sv
// Back end: group -> four characters in an output register, one per cycle unless stalled.
`default_nettype none
`include "assert_macros.svh"
module b64enc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_not_empty,
    input  wire b64enc_pkg::group_t    q_head,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output b64enc_pkg::out_item_t      out_item
);
    import b64enc_pkg::*;

    group_t     cur_reg, cur_next;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg, out_item_next;
    logic       advance;
    logic       last_of_group;
    logic [5:0] sextet;
    logic       is_pad;

    assign advance       = busy_reg && (!out_valid_reg || out_ready);
    assign last_of_group = (idx_reg == CHAR_IDX_FOURTH);
    assign pop           = q_not_empty && (!busy_reg || (advance && last_of_group));

    always_comb
    begin
        case (idx_reg)
            CHAR_IDX_FIRST:  sextet = cur_reg.triple[23:18];
            CHAR_IDX_SECOND: sextet = cur_reg.triple[17:12];
            CHAR_IDX_THIRD:  sextet = cur_reg.triple[11:6];
            default:         sextet = cur_reg.triple[5:0];
        endcase
        is_pad = ((idx_reg == CHAR_IDX_THIRD) && (cur_reg.nbytes == NBYTES_ONE))
              || ((idx_reg == CHAR_IDX_FOURTH) && (cur_reg.nbytes != NBYTES_THREE));
    end

    always_comb
    begin
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (advance)
        begin
            out_item_next.code_char = is_pad ? PAD_CHAR : symbol_of(sextet);
            out_item_next.last_char = last_of_group && cur_reg.eom;
            out_valid_next          = 1'b1;
            idx_next                = idx_reg + 2'd1;
            if (last_of_group)
                busy_next = 1'b0;
        end
        if (pop)
        begin
            cur_next  = q_head;
            busy_next = 1'b1;
            idx_next  = CHAR_IDX_FIRST;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= CHAR_IDX_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // idle back end always waits at the first character
    `ASSERT_PROP(a_idle_idx, clk, rst_n, !busy_reg |-> (idx_reg == CHAR_IDX_FIRST))
    // a character is produced only when the output register is free or draining
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, advance && out_valid_reg && !out_ready)
    // a new group never replaces one still in flight
    `ASSERT_PROP(a_pop_safe, clk, rst_n, pop |-> (!busy_reg || (advance && last_of_group)))
    // end flag only on the fourth character of a group
    `ASSERT_PROP(a_last_pos, clk, rst_n,
        (advance && !last_of_group) |=> !out_item_reg.last_char)

endmodule
`default_nettype wire

// File: src/base64_stream_encoder_unit.sv
// Top level of the streaming Base64 encoder (standard alphabet, '=' padding).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid / in_ready  | in_item  {data_byte, end_of_message}
//  out     | output    | out_valid / out_ready| out_item {code_char, last_char}
//
// in_ready drops only while the group queue is full. A group of up to three bytes yields
// four characters, one per cycle while out_ready is high, from the back end's output
// register, so the sustained input rate is set by the single character path of the back end.
// rst_n clears the held bytes, the queue pointers and the output valid flag.
// Output stalls back up through the queue; the front keeps taking bytes until it fills.
`default_nettype none
module base64_stream_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire b64enc_pkg::in_item_t  in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output b64enc_pkg::out_item_t      out_item
);
    import b64enc_pkg::*;

    // front -> queue
    logic   push;
    group_t push_group;
    logic   queue_full;

    // queue -> back
    logic   pop;
    logic   q_not_empty;
    group_t q_head;

    // Front: holds up to two pending bytes and forms a group on the third byte
    // or on the end-of-message byte, with the missing bytes zero filled.
    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push       (push),
        .push_group (push_group),
        .queue_full (queue_full)
    );

    // Queue: decouples byte intake from character output.
    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // Back: emits the four characters of a group, padding short groups with '='.
    b64enc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule
`default_nettype wire

// File: tb/b64_char_checker.sv
// Checker for the Base64 stream encoder: predicts characters from input transactions.
module b64_char_checker
    import b64enc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_ready,
    input  wire in_item_t  in_item,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    input  wire out_item_t out_item,
    output int             mismatch_count,
    output int             chars_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    string      b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Predicted copy of the encoder's pending bytes.
    logic [15:0] pend_bytes = 16'h0000;
    logic [1:0]  pend_count = 2'd0;
    out_item_t   expected_chars[$];

    initial
    begin
        mismatch_count = 0;
        chars_pending  = 0;
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        return b64_alphabet[s];
    endfunction

    task automatic push_char(input logic [7:0] c, input logic last);
        out_item_t e;
        begin
            e.code_char = c;
            e.last_char = last;
            expected_chars.push_back(e);
        end
    endtask

    // Update pending bytes; queue four characters when a group closes.
    task automatic encode_byte(input in_item_t t);
        logic [23:0] grp;
        begin
            if (pend_count < 2'd2 && !t.end_of_message)
            begin
                if (pend_count == 2'd0)
                    pend_bytes = {t.data_byte, 8'h00};
                else
                    pend_bytes[7:0] = t.data_byte;
                pend_count = pend_count + 2'd1;
            end
            else
            begin
                case (pend_count)
                    2'd0:    grp = {t.data_byte, 16'h0000};
                    2'd1:    grp = {pend_bytes[15:8], t.data_byte, 8'h00};
                    default: grp = {pend_bytes, t.data_byte};
                endcase
                push_char(sextet_char(grp[23:18]), 1'b0);
                push_char(sextet_char(grp[17:12]), 1'b0);
                if (pend_count == 2'd0)
                begin
                    push_char(PAD_CHAR, 1'b0);
                    push_char(PAD_CHAR, 1'b1);
                end
                else if (pend_count == 2'd1)
                begin
                    push_char(sextet_char(grp[11:6]), 1'b0);
                    push_char(PAD_CHAR, 1'b1);
                end
                else
                begin
                    push_char(sextet_char(grp[11:6]), 1'b0);
                    push_char(sextet_char(grp[5:0]), t.end_of_message);
                end
                pend_bytes = 16'h0000;
                pend_count = 2'd0;
            end
        end
    endtask

    task automatic note_mismatch(input out_item_t want, input out_item_t got, input bit none);
        begin
            if (mismatch_count < REPORT_LIMIT)
            begin
                if (none)
                    $display("%0t: unexpected char 0x%02h last=%0b", $realtime,
                             got.code_char, got.last_char);
                else
                    $display("%0t: char mismatch exp 0x%02h last=%0b got 0x%02h last=%0b",
                             $realtime, want.code_char, want.last_char,
                             got.code_char, got.last_char);
            end
            mismatch_count = mismatch_count + 1;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                encode_byte(in_item);
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                    note_mismatch(out_item, out_item, 1'b1);
                else if (expected_chars[0].code_char !== out_item.code_char ||
                         expected_chars[0].last_char !== out_item.last_char)
                begin
                    note_mismatch(expected_chars[0], out_item, 1'b0);
                    void'(expected_chars.pop_front());
                end
                else
                    void'(expected_chars.pop_front());
            end
            chars_pending = expected_chars.size();
        end
    end

endmodule

// File: tb/base64_stream_encoder_unit_tb.sv
// Testbench top for base64_stream_encoder_unit: byte stimulus, clock, reset and verdict.
module base64_stream_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import b64enc_pkg::*;

    // Rough item budget for the random phase; the quiet tail starts near the end.
    localparam int RANDOM_ITEMS = 260;
    localparam int QUIET_TAIL   = 40;
    localparam int DRAIN_CYCLES = 16;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    int mismatch_count;
    int chars_pending;
    int bytes_sent = 0;
    bit idle_en    = 1'b1;   // random gaps on both channels while set

    base64_stream_encoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Watches both channels, predicts every character and counts mismatches.
    b64_char_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the encoder hangs or drops a transaction.
    initial
    begin
        #2ms;
        $display("base64_stream_encoder_unit regression: fail");
        $finish;
    end

    // Receiver side: out_ready is high except for random stall bursts.
    // Changes land on the falling edge so the rising edge sees stable values.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idle_en && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Present one byte and hold it until the encoder takes the transaction.
    // Entered and left on a falling edge; valid is only lowered for an idle burst,
    // so a back-to-back transaction keeps valid high with no glitch.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        begin
            if (idle_en && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            in_valid               <= 1'b1;
            in_item.data_byte      <= b;
            in_item.end_of_message <= eom;
            do
                @(posedge clk);
            while (!in_ready);
            @(negedge clk);
            bytes_sent = bytes_sent + 1;
        end
    endtask

    // Byte content for random messages: mostly uniform, sometimes the extremes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_message(input int len);
        begin
            for (int i = 0; i < len; i++)
                send_byte(pick_byte(), i == len - 1);
        end
    endtask

    initial
    begin
        int  len;
        bit  paused;
        paused = 1'b0;

        // Reset held low, then released on a falling edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: one-byte message, both field extremes -> two symbols and "=="
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two-byte message -> three symbols and "="
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // full group closed by the end mark, last flag on the fourth char
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // group that maps to all '+' symbols
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        // full group without end mark (all '/'), then a one-byte tail
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // four bytes: full group plus a one-byte remainder
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h21, 1'b1);
        // four-byte message (full group plus a one-byte remainder), then a one-byte message
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h20, 1'b1);
        send_byte(8'h31, 1'b1);

        // Random: mostly short messages, some long runs of full groups, and a
        // little noise where the end mark falls at random on any byte.
        while (bytes_sent < RANDOM_ITEMS)
        begin
            if (bytes_sent >= RANDOM_ITEMS - QUIET_TAIL)
                idle_en = 1'b0;

            // Let the encoder drain completely once, mid-run.
            if (!paused && bytes_sent >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (chars_pending != 0);
            end

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    len = $urandom_range(1, 9);
                    send_message(len);
                end
                7:
                begin
                    len = $urandom_range(10, 30);
                    send_message(len);
                end
                default:
                begin
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        send_byte(pick_byte(), $urandom_range(0, 2) == 0);
                end
            endcase
        end
        // Close whatever is still held so every byte shows up as characters.
        send_byte(pick_byte(), 1'b1);
        in_valid <= 1'b0;

        // Drain, then idle for DRAIN_CYCLES to catch any stray character.
        while (chars_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("base64_stream_encoder_unit regression: pass");
        else
            $display("base64_stream_encoder_unit regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/b64enc_pkg.sv
src/b64enc_front.sv
src/b64enc_queue.sv
src/b64enc_back.sv
src/base64_stream_encoder_unit.sv
tb/b64_char_checker.sv
tb/base64_stream_encoder_unit_tb.sv
